// File: hdl/bsks_pkg.sv
// Shared codes, widths and control structures for the bounded stack with key search.
package bsks_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SPREV    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_EXCHANGE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                accept;
    logic                push;
    logic                rd_top;
    logic                pop_done;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                scan_init;
    logic                scan_rd;
    logic                scan_next;
    logic                take_match;
    logic                shift_init;
    logic                shift_rd;
    logic                shift_wr;
    logic                cnt_dec;
    logic                ex_rd_a;
    logic                ex_rd_b;
    logic                ex_wr_a;
    logic                ex_wr_b;
    logic                out_load;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              ex_bad;
    logic              match;
    logic              scan_end;
    logic              top_match;
    logic              shift_end;
    logic              out_free;
  } sts_t;

endpackage

// File: hdl/bsks_ifs.sv
// Valid/ready channel interfaces for operation requests and results.
interface bsks_in_if;
  logic                               valid;
  logic                               ready;
  logic [bsks_pkg::MODE_W-1:0]        mode;
  logic signed [bsks_pkg::VALUE_W-1:0] value;
  logic [bsks_pkg::POS_W-1:0]         position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface bsks_out_if;
  logic                                valid;
  logic                                ready;
  logic [bsks_pkg::STATUS_W-1:0]       status;
  logic                                found;
  logic [bsks_pkg::POS_W-1:0]          found_position;
  logic signed [bsks_pkg::VALUE_W-1:0] found_value;
  logic [bsks_pkg::COUNT_W-1:0]        entry_count_out;
  logic                                is_empty;

  modport source (output valid, output status, output found, output found_position,
                  output found_value, output entry_count_out, output is_empty, input ready);
  modport sink   (input valid, input status, input found, input found_position,
                  input found_value, input entry_count_out, input is_empty, output ready);
endinterface

// File: hdl/bsks_ctrl.sv
// Operation sequencer for the stack: steps each transaction through its memory accesses.
module bsks_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bsks_pkg::sts_t  sts,
  output bsks_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_POP      = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CMP = 4'd4;
  localparam logic [3:0] S_SHIFT_RD = 4'd5;
  localparam logic [3:0] S_SHIFT_WR = 4'd6;
  localparam logic [3:0] S_EX_B     = 4'd7;
  localparam logic [3:0] S_EX_WA    = 4'd8;
  localparam logic [3:0] S_EX_WB    = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        case (sts.mode)
          bsks_pkg::MODE_PUSH: begin
            if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = bsks_pkg::ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          bsks_pkg::MODE_POP: begin
            if (sts.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = bsks_pkg::ST_EMPTY;
            end else begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_POP;
            end
          end
          bsks_pkg::MODE_SEARCH, bsks_pkg::MODE_SPREV, bsks_pkg::MODE_DELETE: begin
            if (sts.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = bsks_pkg::ST_EMPTY;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN_RD;
            end
          end
          bsks_pkg::MODE_EXCHANGE: begin
            if (sts.ex_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = bsks_pkg::ST_RANGE;
            end else begin
              cmd.ex_rd_a = 1'b1;
              state_nxt   = S_EX_B;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        cmd.pop_done = 1'b1;
        state_nxt    = S_FIN;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          cmd.take_match = 1'b1;
          state_nxt      = S_FIN;
          if (sts.mode == bsks_pkg::MODE_DELETE) begin
            if (sts.top_match) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.shift_init = 1'b1;
              state_nxt      = S_SHIFT_RD;
            end
          end
        end else if (sts.scan_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = bsks_pkg::ST_NOT_FOUND;
          state_nxt       = S_FIN;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_nxt    = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        if (sts.shift_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_EX_B: begin
        cmd.ex_rd_b = 1'b1;
        state_nxt   = S_EX_WA;
      end
      S_EX_WA: begin
        cmd.ex_wr_a = 1'b1;
        state_nxt   = S_EX_WB;
      end
      S_EX_WB: begin
        cmd.ex_wr_b = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/bsks_dp.sv
// Stack datapath: entry memory, count, scan pointers, result and output registers.
module bsks_dp #(
  parameter int STACK_DEPTH = bsks_pkg::STACK_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bsks_pkg::cmd_t                       cmd,
  output bsks_pkg::sts_t                       sts,
  input  logic [bsks_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [bsks_pkg::VALUE_W-1:0]  in_value,
  input  logic [bsks_pkg::POS_W-1:0]           in_position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bsks_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_found,
  output logic [bsks_pkg::POS_W-1:0]           out_found_position,
  output logic signed [bsks_pkg::VALUE_W-1:0]  out_found_value,
  output logic [bsks_pkg::COUNT_W-1:0]         out_entry_count_out,
  output logic                                 out_is_empty
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = ((CW > bsks_pkg::POS_W) ? CW : bsks_pkg::POS_W) + 1;
  localparam int VW = bsks_pkg::VALUE_W;

  // Entries are kept bottom first: the top of the stack lives at address count-1.
  logic [VW-1:0] mem [STACK_DEPTH];

  logic [bsks_pkg::MODE_W-1:0]   mode_r;
  logic [VW-1:0]                 key_r;
  logic [bsks_pkg::POS_W-1:0]    pos_r;
  logic [CW-1:0]                 count_r;
  logic [AW-1:0]                 p_r;
  logic [AW-1:0]                 addr_r;
  logic [VW-1:0]                 rd_data_r;
  logic [VW-1:0]                 prev_r;
  logic [VW-1:0]                 tmp_r;
  logic [bsks_pkg::STATUS_W-1:0] res_status_r;
  logic                          res_found_r;
  logic [AW-1:0]                 res_fpos_r;
  logic [VW-1:0]                 res_fval_r;
  logic                          out_valid_r;
  logic [bsks_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_found_r;
  logic [bsks_pkg::POS_W-1:0]    out_fpos_r;
  logic [VW-1:0]                 out_fval_r;
  logic [bsks_pkg::COUNT_W-1:0]  out_count_r;
  logic                          out_empty_r;

  logic [CW-1:0] count_m1;
  logic [CW-1:0] scan_phys;
  logic [CW-1:0] shift_start;
  logic [EW-1:0] ex_a_full;
  logic [AW-1:0] ex_a;
  logic [AW-1:0] ex_b;
  logic          ex_bad;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  assign count_m1    = count_r - CW'(1);
  assign scan_phys   = count_m1 - CW'(p_r);
  assign shift_start = count_r - CW'(p_r);
  assign ex_a_full   = EW'(count_r) - EW'(pos_r) - EW'(2);
  assign ex_a        = ex_a_full[AW-1:0];
  assign ex_b        = AW'(ex_a - 1'b1);
  assign ex_bad      = (EW'(pos_r) + EW'(2)) >= EW'(count_r);

  always_comb begin
    sts.mode      = mode_r;
    sts.full      = (count_r == CW'(STACK_DEPTH));
    sts.empty     = (count_r == '0);
    sts.ex_bad    = ex_bad;
    // Search previous may only match from the second entry down.
    sts.match     = (rd_data_r == key_r) &&
                    !((mode_r == bsks_pkg::MODE_SPREV) && (p_r == '0));
    sts.scan_end  = (CW'(p_r) + CW'(1)) >= count_r;
    sts.top_match = (p_r == '0);
    sts.shift_end = (CW'(addr_r) == count_m1);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = count_m1[AW-1:0];
    if (cmd.scan_rd) begin
      rd_addr = scan_phys[AW-1:0];
    end else if (cmd.shift_rd) begin
      rd_addr = addr_r;
    end else if (cmd.ex_rd_a) begin
      rd_addr = ex_a;
    end else if (cmd.ex_rd_b) begin
      rd_addr = ex_b;
    end else if (!cmd.rd_top) begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = count_r[AW-1:0];
    wr_data = key_r;
    if (cmd.shift_wr) begin
      wr_addr = AW'(addr_r - 1'b1);
      wr_data = rd_data_r;
    end else if (cmd.ex_wr_a) begin
      wr_addr = ex_a;
      wr_data = rd_data_r;
    end else if (cmd.ex_wr_b) begin
      wr_addr = ex_b;
      wr_data = tmp_r;
    end else if (!cmd.push) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Transaction operands, scan state and the pending result.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r       <= in_mode;
      key_r        <= in_value;
      pos_r        <= in_position;
      res_status_r <= bsks_pkg::ST_OK;
      res_found_r  <= 1'b0;
      res_fpos_r   <= '0;
      res_fval_r   <= '0;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status_code;
    end
    if (cmd.pop_done) begin
      res_fval_r <= rd_data_r;
    end
    if (cmd.scan_init) begin
      p_r <= '0;
    end
    if (cmd.scan_next) begin
      prev_r <= rd_data_r;
      p_r    <= AW'(p_r + 1'b1);
    end
    if (cmd.take_match) begin
      res_found_r <= 1'b1;
      if (mode_r == bsks_pkg::MODE_SPREV) begin
        res_fpos_r <= AW'(p_r - 1'b1);
        res_fval_r <= prev_r;
      end else begin
        res_fpos_r <= p_r;
        res_fval_r <= rd_data_r;
      end
    end
    if (cmd.shift_init) begin
      addr_r <= shift_start[AW-1:0];
    end
    if (cmd.shift_wr) begin
      addr_r <= AW'(addr_r + 1'b1);
    end
    if (cmd.ex_rd_b) begin
      tmp_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push) begin
      count_r <= CW'(count_r + 1'b1);
    end else if (cmd.pop_done || cmd.cnt_dec) begin
      count_r <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_fpos_r   <= bsks_pkg::POS_W'(res_fpos_r);
      out_fval_r   <= res_fval_r;
      out_count_r  <= bsks_pkg::COUNT_W'(count_r);
      out_empty_r  <= (count_r == '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found           = out_found_r;
  assign out_found_position  = out_fpos_r;
  assign out_found_value     = out_fval_r;
  assign out_entry_count_out = out_count_r;
  assign out_is_empty        = out_empty_r;

endmodule

// File: hdl/bounded_stack_with_key_search_core.sv
// Bounded stack top level: one transaction in flight, results held in an output register.
// A push, query or rejected operation goes from dispatch straight to the result state; a pop
// reads the top entry first, an exchange reads both entries then writes them back, a search
// reads and compares one entry at a time from the top, and a delete then moves each entry
// above the match down by one. The next transaction is taken once the result is loaded.
// Reset (synchronous, active low) empties the stack and the output; the entry memory is
// not cleared and needs no clearing pass.
module bounded_stack_with_key_search_core #(
  parameter int STACK_DEPTH = bsks_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bsks_in_if.sink           in_ch,
  bsks_out_if.source        out_ch
);

  bsks_pkg::cmd_t cmd;
  bsks_pkg::sts_t sts;

  bsks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsks_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_ch.mode),
    .in_value            (in_ch.value),
    .in_position         (in_ch.position),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_status          (out_ch.status),
    .out_found           (out_ch.found),
    .out_found_position  (out_ch.found_position),
    .out_found_value     (out_ch.found_value),
    .out_entry_count_out (out_ch.entry_count_out),
    .out_is_empty        (out_ch.is_empty)
  );

endmodule
